// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked, reset-qualified checks used across the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: rtl/bnc_pkg.sv
// ---------------------------------------------------------------------------
// Bracket nesting checker package
// Shared constants, bracket kind codes, decode function and control structs.
// ---------------------------------------------------------------------------
package bnc_pkg;

  localparam int STACK_DEPTH_DEF   = 256;
  localparam int POSITION_BITS_DEF = 16;
  localparam int ERRPOS_W          = 16;
  localparam int CH_W              = 8;
  localparam int IN_TDATA_W        = 8;
  localparam int OUT_TDATA_W       = 24;

  localparam logic [CH_W-1:0] CH_ROUND_OPEN   = 8'h28; // (
  localparam logic [CH_W-1:0] CH_ROUND_CLOSE  = 8'h29; // )
  localparam logic [CH_W-1:0] CH_SQUARE_OPEN  = 8'h5B; // [
  localparam logic [CH_W-1:0] CH_SQUARE_CLOSE = 8'h5D; // ]
  localparam logic [CH_W-1:0] CH_CURLY_OPEN   = 8'h7B; // {
  localparam logic [CH_W-1:0] CH_CURLY_CLOSE  = 8'h7D; // }
  localparam logic [CH_W-1:0] CH_ANGLE_OPEN   = 8'h3C; // <
  localparam logic [CH_W-1:0] CH_ANGLE_CLOSE  = 8'h3E; // >

  typedef enum logic [1:0] {
    KIND_ROUND,
    KIND_SQUARE,
    KIND_CURLY,
    KIND_ANGLE
  } kind_t;

  typedef struct packed {
    logic  is_open;
    logic  is_close;
    kind_t kind;
  } chr_class_t;

  // Stack command from the scanner
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } stack_op_t;

  // Stack occupancy flags
  typedef struct packed {
    logic empty;
    logic single;
    logic full;
  } stack_stat_t;

  function automatic chr_class_t classify(input logic [CH_W-1:0] ch);
    chr_class_t c;
    c = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_ROUND};
    case (ch)
      CH_ROUND_OPEN:   c = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_ROUND};
      CH_SQUARE_OPEN:  c = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_SQUARE};
      CH_CURLY_OPEN:   c = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_CURLY};
      CH_ANGLE_OPEN:   c = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_ANGLE};
      CH_ROUND_CLOSE:  c = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_ROUND};
      CH_SQUARE_CLOSE: c = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_SQUARE};
      CH_CURLY_CLOSE:  c = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_CURLY};
      CH_ANGLE_CLOSE:  c = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_ANGLE};
      default:         c = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_ROUND};
    endcase
    return c;
  endfunction

endpackage

// File: rtl/bracket_nesting_checker.sv
// Path: the final character of a string is accepted into the input register;
// its verdict is loaded into the result register when that register can
// advance and is then presented on out_tvalid.
// Throughput: one character per cycle; a result held by out_tready low
// stalls the input. Push and pop follow each other with no gap.
// Reset: synchronous, active low; clears control and string state. The stack
// memory is not cleared; entries are used only where written in the current string.
// ---------------------------------------------------------------------------
// Bracket nesting checker
// Streams characters, checks bracket nesting and reports one verdict per
// string on its final character.
// ---------------------------------------------------------------------------
module bracket_nesting_checker #(
  parameter int STACK_DEPTH   = bnc_pkg::STACK_DEPTH_DEF,
  parameter int POSITION_BITS = bnc_pkg::POSITION_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [bnc_pkg::IN_TDATA_W-1:0]     in_tdata,  // [7:0] ch
  input  logic                               in_tlast,  // last
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [bnc_pkg::OUT_TDATA_W-1:0]    out_tdata  // [0] balanced,
                                                         // [16:1] error_position,
                                                         // [17] overflow, [23:18] zero
);
  import bnc_pkg::*;

  logic                     in_valid_r;
  logic [CH_W-1:0]          ch_r;
  logic                     last_r;
  logic                     advance;
  logic                     fire;
  stack_op_t                op;
  stack_stat_t              stat;
  kind_t                    push_kind;
  kind_t                    top_kind;
  logic [POSITION_BITS-1:0] push_pos;
  logic [POSITION_BITS-1:0] top_pos;
  logic [POSITION_BITS-1:0] below_pos;
  logic                     res_valid;
  logic                     res_balanced;
  logic [ERRPOS_W-1:0]      res_error_position;
  logic                     res_overflow;
  logic                     out_valid_r;
  logic [OUT_TDATA_W-1:0]   out_data_r;

  assign advance   = !out_valid_r || out_tready;
  assign fire      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  // Input register: hold the character until the scanner consumes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      ch_r   <= in_tdata[CH_W-1:0];
      last_r <= in_tlast;
    end
  end

  bnc_scan #(
    .POSITION_BITS (POSITION_BITS)
  ) u_scan (
    .clk                (clk),
    .rst_n              (rst_n),
    .fire               (fire),
    .ch                 (ch_r),
    .last               (last_r),
    .stat               (stat),
    .top_kind           (top_kind),
    .top_pos            (top_pos),
    .below_pos          (below_pos),
    .op                 (op),
    .push_kind          (push_kind),
    .push_pos           (push_pos),
    .res_valid          (res_valid),
    .res_balanced       (res_balanced),
    .res_error_position (res_error_position),
    .res_overflow       (res_overflow)
  );

  bnc_stack #(
    .STACK_DEPTH   (STACK_DEPTH),
    .POSITION_BITS (POSITION_BITS)
  ) u_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .push_kind (push_kind),
    .push_pos  (push_pos),
    .stat      (stat),
    .top_kind  (top_kind),
    .top_pos   (top_pos),
    .below_pos (below_pos)
  );

  // Result register: advance when empty or when the transaction is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_data_r <= {{(OUT_TDATA_W - ERRPOS_W - 2){1'b0}},
                     res_overflow, res_error_position, res_balanced};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: rtl/bnc_stack.sv
// ---------------------------------------------------------------------------
// Bracket stack
// Opener kinds and positions in a memory, with the top entry and the entry
// below it held in registers so push and pop run every cycle.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bnc_stack #(
  parameter int STACK_DEPTH   = 256,
  parameter int POSITION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  bnc_pkg::stack_op_t       op,
  input  bnc_pkg::kind_t           push_kind,
  input  logic [POSITION_BITS-1:0] push_pos,
  output bnc_pkg::stack_stat_t     stat,
  output bnc_pkg::kind_t           top_kind,
  output logic [POSITION_BITS-1:0] top_pos,
  output logic [POSITION_BITS-1:0] below_pos
);
  import bnc_pkg::*;

  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int EW = 2 + POSITION_BITS;

  logic [EW-1:0] mem [STACK_DEPTH];
  logic [DW-1:0] depth_r, depth_nxt;
  logic [EW-1:0] top_r, top_nxt;
  logic [EW-1:0] below_r;
  logic [EW-1:0] push_entry;
  logic [AW-1:0] rd_addr;

  assign push_entry = {push_kind, push_pos};

  always_comb begin
    if (op.clear) begin
      depth_nxt = '0;
    end else if (op.push) begin
      depth_nxt = depth_r + DW'(1);
    end else if (op.pop) begin
      depth_nxt = depth_r - DW'(1);
    end else begin
      depth_nxt = depth_r;
    end
  end

  always_comb begin
    if (op.push) begin
      top_nxt = push_entry;
    end else if (op.pop) begin
      top_nxt = below_r;
    end else begin
      top_nxt = top_r;
    end
  end

  // Prefetch the entry that sits below the top after this update
  assign rd_addr = AW'(depth_nxt - DW'(2));

  always_ff @(posedge clk) begin
    if (op.push) begin
      mem[depth_r[AW-1:0]] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    below_r <= mem[rd_addr];
    top_r   <= top_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else begin
      depth_r <= depth_nxt;
    end
  end

  assign stat.empty  = (depth_r == '0);
  assign stat.single = (depth_r == DW'(1));
  assign stat.full   = (depth_r == DW'(STACK_DEPTH));
  assign top_kind    = kind_t'(top_r[EW-1 -: 2]);
  assign top_pos     = top_r[POSITION_BITS-1:0];
  assign below_pos   = below_r[POSITION_BITS-1:0];

  `ASSERT_IMPLIES(a_no_push_full, clk, rst_n, stat.full, !op.push)
  `ASSERT_IMPLIES(a_no_pop_empty, clk, rst_n, stat.empty, !op.pop)
  `ASSERT_NEXT(a_clear_empties, clk, rst_n, op.clear, stat.empty)

endmodule

// File: rtl/bnc_scan.sv
// ---------------------------------------------------------------------------
// Bracket scanner
// Decodes one character, counts positions, records the first nesting fault
// and forms the verdict on the final character of a string.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bnc_scan #(
  parameter int POSITION_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            fire,
  input  logic [bnc_pkg::CH_W-1:0]        ch,
  input  logic                            last,
  input  bnc_pkg::stack_stat_t            stat,
  input  bnc_pkg::kind_t                  top_kind,
  input  logic [POSITION_BITS-1:0]        top_pos,
  input  logic [POSITION_BITS-1:0]        below_pos,
  output bnc_pkg::stack_op_t              op,
  output bnc_pkg::kind_t                  push_kind,
  output logic [POSITION_BITS-1:0]        push_pos,
  output logic                            res_valid,
  output logic                            res_balanced,
  output logic [bnc_pkg::ERRPOS_W-1:0]    res_error_position,
  output logic                            res_overflow
);
  import bnc_pkg::*;

  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [POSITION_BITS-1:0] fault_r, fault_nxt;
  logic                     err_r, err_nxt;
  logic                     ovf_r, ovf_nxt;
  logic [POSITION_BITS-1:0] pos_cur;
  logic                     pos_sat;
  logic                     active;
  logic                     close_err;
  logic                     open_drop;
  logic                     remain;
  logic [POSITION_BITS-1:0] remain_pos;
  chr_class_t               cls;

  assign cls     = classify(ch);
  assign pos_sat = (pos_r == '1);
  assign pos_cur = pos_sat ? pos_r : pos_r + POSITION_BITS'(1);
  assign active  = fire && !err_r;

  assign op.push   = active && cls.is_open && !stat.full;
  assign op.pop    = active && cls.is_close && !stat.empty;
  assign op.clear  = fire && last;
  assign push_kind = cls.kind;
  assign push_pos  = pos_cur;

  assign open_drop = active && cls.is_open && stat.full;
  assign close_err = active && cls.is_close && (stat.empty || (top_kind != cls.kind));

  assign err_nxt   = err_r || close_err;
  assign fault_nxt = close_err ? pos_cur : fault_r;
  assign ovf_nxt   = ovf_r || (fire && pos_sat) || open_drop;
  assign pos_nxt   = fire ? pos_cur : pos_r;

  // Innermost opener still open after this character
  always_comb begin
    if (op.push) begin
      remain     = 1'b1;
      remain_pos = pos_cur;
    end else if (op.pop) begin
      remain     = !stat.single;
      remain_pos = below_pos;
    end else begin
      remain     = !stat.empty;
      remain_pos = top_pos;
    end
  end

  assign res_valid          = fire && last;
  assign res_balanced       = !err_nxt && !remain;
  assign res_overflow       = ovf_nxt;
  assign res_error_position = err_nxt ? ERRPOS_W'(fault_nxt)
                            : (remain ? ERRPOS_W'(remain_pos) : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      fault_r <= '0;
      err_r   <= 1'b0;
      ovf_r   <= 1'b0;
    end else if (fire && last) begin
      pos_r   <= '0;
      fault_r <= '0;
      err_r   <= 1'b0;
      ovf_r   <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      fault_r <= fault_nxt;
      err_r   <= err_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  `ASSERT_IMPLIES(a_fault_nonzero, clk, rst_n, err_r, fault_r != '0)
  `ASSERT_NEXT(a_string_restart, clk, rst_n, fire && last, (pos_r == '0) && !err_r && !ovf_r)

endmodule
